// ===== rtl/two_class_fifo_oldest_select_assert.svh =====
// assertion macros shared by the two-class fifo checker
`ifndef TWO_CLASS_FIFO_OLDEST_SELECT_ASSERT_SVH
`define TWO_CLASS_FIFO_OLDEST_SELECT_ASSERT_SVH

// same-cycle implication, held off during reset
`define TCFOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define TCFOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcfos_pkg.sv =====
// types and codes of the two-class fifo with oldest-entry select
`timescale 1ns / 1ps

package tcfos_pkg;

    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_ANY   = 2'd1;
    localparam logic [1:0] OP_SEL   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int unsigned PORT_PAY_W = 16;

    typedef struct packed {
        logic [1:0]            operation;
        logic                  entry_class;
        logic [PORT_PAY_W-1:0] payload_in;
    } tcfos_in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  class_out;
        logic [PORT_PAY_W-1:0] payload_out;
    } tcfos_out_t;

    typedef struct packed {
        logic load;
        logic shift;
    } tcfos_cell_ctl_t;

endpackage

// ===== rtl/tcfos_cell.sv =====
// one queue slot: holds an entry, loads a new one or takes its younger neighbor's
`timescale 1ns / 1ps

module tcfos_cell
    import tcfos_pkg::*;
#(
    parameter int unsigned PAYLOAD_BITS = 16
)
(
    input  logic                    clk,
    input  tcfos_cell_ctl_t         ctl,
    input  logic                    load_cls,
    input  logic [PAYLOAD_BITS-1:0] load_pay,
    input  logic                    nbr_cls,
    input  logic [PAYLOAD_BITS-1:0] nbr_pay,
    output logic                    cls,
    output logic [PAYLOAD_BITS-1:0] pay
);

    logic                    cls_reg;
    logic                    cls_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] pay_next;

    always_comb
    begin
        cls_next = cls_reg;
        pay_next = pay_reg;
        if (ctl.load)
        begin
            cls_next = load_cls;
            pay_next = load_pay;
        end
        else if (ctl.shift)
        begin
            cls_next = nbr_cls;
            pay_next = nbr_pay;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
        pay_reg <= pay_next;
    end

    assign cls = cls_reg;
    assign pay = pay_reg;

endmodule

// ===== rtl/two_class_fifo_oldest_select.sv =====
// Two-class fifo with oldest-entry select. Takes one operation per clock: enqueue, remove the
// oldest entry, or remove the oldest entry of a chosen class; the remaining entries close up in
// arrival order. Each item gives exactly one result, registered and shown the cycle after the
// item is taken. in_ready drops only while a result waits in the output register and out_ready
// is low. The entries sit in a row of DEPTH cells, oldest at cell 0; a removal moves every entry above
// the removed one down by one place in the same cycle. The update path is set by the
// first-match search across the row (one DEPTH-bit subtract) and the removed-entry select.
`timescale 1ns / 1ps

module two_class_fifo_oldest_select
    import tcfos_pkg::*;
#(
    parameter int unsigned DEPTH        = 16,
    parameter int unsigned PAYLOAD_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tcfos_in_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output tcfos_out_t out_item
);

    localparam int unsigned OCC_W = $clog2(DEPTH + 1);

    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        occ_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    tcfos_out_t              out_item_reg;
    tcfos_out_t              out_item_next;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    is_enq;
    logic                    is_remove;
    logic                    do_enq;
    logic                    do_remove;
    logic [PAYLOAD_BITS-1:0] pay_trim;
    logic [DEPTH-1:0]        match;
    logic [DEPTH-1:0]        first_hit;
    logic [DEPTH-1:0]        shift_mask;
    logic [DEPTH-1:0]        load_mask;
    logic                    rm_cls;
    logic [PAYLOAD_BITS-1:0] rm_pay;
    logic [PORT_PAY_W-1:0]   rm_pay_port;

    logic                    cell_cls [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
    tcfos_cell_ctl_t         cell_ctl [DEPTH];

    assign accept = in_valid && in_ready;
    assign full   = (occ_reg == OCC_W'(DEPTH));
    assign empty  = (occ_reg == '0);

    // width fit between the 16-bit port field and the stored payload
    generate
        if (PAYLOAD_BITS > PORT_PAY_W)
        begin : g_wide
            assign pay_trim    = {{(PAYLOAD_BITS - PORT_PAY_W){1'b0}}, in_item.payload_in};
            assign rm_pay_port = rm_pay[PORT_PAY_W-1:0];
        end
        else if (PAYLOAD_BITS == PORT_PAY_W)
        begin : g_same
            assign pay_trim    = in_item.payload_in;
            assign rm_pay_port = rm_pay;
        end
        else
        begin : g_narrow
            assign pay_trim    = in_item.payload_in[PAYLOAD_BITS-1:0];
            assign rm_pay_port = {{(PORT_PAY_W - PAYLOAD_BITS){1'b0}}, rm_pay};
        end
    endgenerate

    always_comb
    begin
        is_enq    = 1'b0;
        is_remove = 1'b0;
        unique case (in_item.operation)
            OP_ENQ:         is_enq    = 1'b1;
            OP_ANY, OP_SEL: is_remove = 1'b1;
            default:        ;
        endcase
    end

    // per-cell hit: occupied and, for a class select, of the wanted class
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_match
            assign match[i] = (occ_reg > OCC_W'(i)) &&
                              ((in_item.operation != OP_SEL) ||
                               (cell_cls[i] == in_item.entry_class));
            assign load_mask[i] = (occ_reg == OCC_W'(i));
        end
    endgenerate

    // lowest set bit, and every cell from it upward
    assign first_hit  = match & ~(match - DEPTH'(1));
    assign shift_mask = ~(~match & (match - DEPTH'(1)));

    assign do_enq    = accept && is_enq && !full;
    assign do_remove = accept && is_remove && (match != '0);

    always_comb
    begin
        rm_cls = 1'b0;
        rm_pay = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rm_cls = rm_cls | (first_hit[i] & cell_cls[i]);
            rm_pay = rm_pay | ({PAYLOAD_BITS{first_hit[i]}} & cell_pay[i]);
        end
    end

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                    nbr_cls;
            logic [PAYLOAD_BITS-1:0] nbr_pay;

            if (i == DEPTH - 1)
            begin : g_last
                assign nbr_cls = cell_cls[i];
                assign nbr_pay = cell_pay[i];
            end
            else
            begin : g_inner
                assign nbr_cls = cell_cls[i+1];
                assign nbr_pay = cell_pay[i+1];
            end

            assign cell_ctl[i].load  = do_enq && load_mask[i];
            assign cell_ctl[i].shift = do_remove && shift_mask[i];

            tcfos_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[i]),
                .load_cls (in_item.entry_class),
                .load_pay (pay_trim),
                .nbr_cls  (nbr_cls),
                .nbr_pay  (nbr_pay),
                .cls      (cell_cls[i]),
                .pay      (cell_pay[i])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next = occ_reg;
        if (do_enq)
            occ_next = occ_reg + OCC_W'(1);
        else if (do_remove)
            occ_next = occ_reg - OCC_W'(1);
    end

    always_comb
    begin
        out_item_next             = out_item_reg;
        out_valid_next            = out_valid_reg && !out_ready;
        if (accept)
        begin
            out_valid_next            = 1'b1;
            out_item_next.status      = ST_OK;
            out_item_next.class_out   = 1'b0;
            out_item_next.payload_out = '0;
            if (is_enq)
            begin
                if (full)
                    out_item_next.status = ST_FULL;
            end
            else if (is_remove)
            begin
                if (empty)
                    out_item_next.status = ST_EMPTY;
                else if (match == '0)
                    out_item_next.status = ST_NONE;
                else
                begin
                    out_item_next.class_out   = rm_cls;
                    out_item_next.payload_out = rm_pay_port;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/tcfos_checker.sv =====
// port-level checks for the two-class fifo, bound to the top level
`timescale 1ns / 1ps

`include "two_class_fifo_oldest_select_assert.svh"

module tcfos_checker
    import tcfos_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input tcfos_in_t  in_item,
    input logic       out_valid,
    input logic       out_ready,
    input tcfos_out_t out_item
);

    // a waiting result holds until taken
    `TCFOS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

    // an empty output register never blocks the input side
    `TCFOS_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid, in_ready, "input stalled with no result pending")

    // every accepted item gives a result next cycle
    `TCFOS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "no result after accepted item")

    // failed results carry no entry
    `TCFOS_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_item.status != ST_OK, out_item.class_out == 1'b0 && out_item.payload_out == '0, "failed result carries an entry")

    // an enqueue only reports ok or full
    `TCFOS_ASSERT_NEXT(a_enq_status, clk, rst_n, in_valid && in_ready && in_item.operation == OP_ENQ, out_item.status == ST_OK || out_item.status == ST_FULL, "bad enqueue status")

endmodule

bind two_class_fifo_oldest_select tcfos_checker u_tcfos_checker (.*);
